@@ hw/rtl/bpa_pkg.sv @@
// Package for the bitmap page allocator: sizes, codes and shared types.
package bpa_pkg;
   localparam int MapWords = 1024;
   localparam int WordBits = 64;
   localparam int WordAw = $clog2(MapWords);
   localparam int BitAw = 6;
   localparam int PageW = 17;
   localparam int TotalPages = MapWords * WordBits;
   localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE = 1'b1;

   // memory port request from the sequencer
   typedef struct packed {
      logic              rd;
      logic [WordAw-1:0] rd_addr;
      logic              wr;
      logic [WordAw-1:0] wr_addr;
      logic [63:0]       wr_data;
   } mem_req_type;
endpackage

@@ hw/rtl/bitmap_page_allocator_unit.sv @@
// Top level of the bitmap page allocator: sequencer around the map memory.
// Requests are handled one at a time; the next is taken once the response has
// gone. A zero-count allocation or an out-of-range free is answered straight
// from idle; a free of a page inside the map reads its word, writes it back
// with the bit cleared, then responds. An allocation takes the request, then
// scans one page per cycle from the hint, first fetching each 64-bit word it
// visits. It then marks the run one page per cycle, fetching each word of the
// run first, and hands over the response. After reset and after every csr
// write the memory is rebuilt by a clearing pass over all 1024 words, one word
// a cycle, during which no request is taken (csr writes still are).
module bitmap_page_allocator_unit
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_first_free_page,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [16:0] req_page_count,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [27:0] rsp_page_address,
   output logic        rsp_failed
);
   typedef enum logic [7:0] {
      ST_INIT  = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_FRD   = 8'b0000_0100,
      ST_FWR   = 8'b0000_1000,
      ST_SRD   = 8'b0001_0000,
      ST_SCAN  = 8'b0010_0000,
      ST_MARK  = 8'b0100_0000,
      ST_MWAIT = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [16:0]   first_ff, first_in;
   logic [16:0]   hint_ff, hint_in;
   logic [WordAw:0] clr_ff, clr_in;
   logic [16:0]   count_ff, count_in;
   logic [16:0]   start_ff, start_in;
   logic [16:0]   cur_ff, cur_in;   // page under test
   logic [16:0]   run_ff, run_in;   // pages found / marked so far
   logic [63:0]   word_ff, word_in;
   logic          wvalid_ff, wvalid_in;
   logic          rvalid_ff, rvalid_in;
   logic [27:0]   addr_ff, addr_in;
   logic          fail_ff, fail_in;
   logic [16:0]   fpage_ff, fpage_in;
   mem_req_type   mem_req;
   logic [63:0]   rd_data;
   logic [63:0]   w_cur;

   bpa_map_ram u_ram (.clock(clock), .mem_req(mem_req), .rd_data(rd_data));

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE) || rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_page_address = addr_ff;
   assign rsp_failed = fail_ff;
   assign w_cur = wvalid_ff ? word_ff : rd_data;

   // sequencer
   always_comb begin
      state_in = state_ff; first_in = first_ff; hint_in = hint_ff; clr_in = clr_ff;
      count_in = count_ff; start_in = start_ff; cur_in = cur_ff; run_in = run_ff;
      word_in = word_ff; wvalid_in = wvalid_ff; rvalid_in = rvalid_ff;
      addr_in = addr_ff; fail_in = fail_ff; fpage_in = fpage_ff;
      mem_req = '0;
      if (rvalid_ff && !rsp_stall) rvalid_in = 1'b0;
      case (state_ff)
         ST_INIT: begin
            mem_req.wr = 1'b1;
            mem_req.wr_addr = clr_ff[WordAw-1:0];
            mem_req.wr_data = ({1'b0, clr_ff} < {1'b0, first_ff[16:6]}) ? AllOnes : '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (WordAw+1)'(MapWords-1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               addr_in = '0; fail_in = 1'b0;
               if (req_func == FUNC_FREE) begin
                  fpage_in = {1'b0, req_free_address[WordAw+BitAw+11:12]};
                  if (req_free_address[31:12] < 20'(TotalPages)) begin
                     mem_req.rd = 1'b1;
                     mem_req.rd_addr = req_free_address[WordAw+BitAw+11:BitAw+12];
                     state_in = ST_FRD;
                  end else rvalid_in = 1'b1;
               end else if (req_page_count == '0) begin
                  fail_in = 1'b1; rvalid_in = 1'b1;
               end else begin
                  count_in = req_page_count;
                  start_in = hint_ff; cur_in = hint_ff; run_in = '0;
                  state_in = ST_SRD;
               end
            end
         end
         ST_FRD: state_in = ST_FWR;
         ST_FWR: begin
            mem_req.wr = 1'b1;
            mem_req.wr_addr = fpage_ff[WordAw+BitAw-1:BitAw];
            mem_req.wr_data = rd_data & ~(64'd1 << fpage_ff[BitAw-1:0]);
            if (fpage_ff < hint_ff) hint_in = fpage_ff;
            rvalid_in = 1'b1; state_in = ST_IDLE;
         end
         ST_SRD: begin
            // fetch the word holding cur, or fail past the top
            if ({1'b0, cur_ff} >= 18'(TotalPages)) begin
               fail_in = 1'b1; rvalid_in = 1'b1; state_in = ST_IDLE;
            end else begin
               mem_req.rd = 1'b1; mem_req.rd_addr = cur_ff[WordAw+BitAw-1:BitAw];
               wvalid_in = 1'b0; state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // test one page per cycle
            wvalid_in = 1'b1; word_in = w_cur;
            if (w_cur[cur_ff[BitAw-1:0]]) begin
               start_in = cur_ff + 1'b1; run_in = '0;
            end else run_in = run_ff + 1'b1;
            cur_in = cur_ff + 1'b1;
            if (!w_cur[cur_ff[BitAw-1:0]] && (run_ff + 1'b1 == count_ff)) begin
               cur_in = start_ff; run_in = '0; state_in = ST_MWAIT;
            end else if (cur_ff[BitAw-1:0] == '1) state_in = ST_SRD;
         end
         ST_MWAIT: begin
            // read word of the next page to mark
            mem_req.rd = 1'b1; mem_req.rd_addr = cur_ff[WordAw+BitAw-1:BitAw];
            wvalid_in = 1'b0; state_in = ST_MARK;
         end
         ST_MARK: begin
            word_in = w_cur | (64'd1 << cur_ff[BitAw-1:0]);
            wvalid_in = 1'b1;
            run_in = run_ff + 1'b1; cur_in = cur_ff + 1'b1;
            if ((run_ff + 1'b1 == count_ff) || (cur_ff[BitAw-1:0] == '1)) begin
               mem_req.wr = 1'b1; mem_req.wr_addr = cur_ff[WordAw+BitAw-1:BitAw];
               mem_req.wr_data = word_in;
               if (run_ff + 1'b1 == count_ff) begin
                  hint_in = start_ff + count_ff;
                  addr_in = {start_ff[15:0], 12'd0};
                  rvalid_in = 1'b1; state_in = ST_IDLE;
               end else state_in = ST_MWAIT;
            end
         end
         default: state_in = ST_INIT;
      endcase
      // csr write rebuilds the map
      if (csr_valid && csr_ready) begin
         first_in = csr_first_free_page; hint_in = csr_first_free_page;
         clr_in = '0; state_in = ST_INIT;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; first_ff <= '0; hint_ff <= '0; clr_ff <= '0;
         rvalid_ff <= 1'b0; wvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; first_ff <= first_in; hint_ff <= hint_in;
         clr_ff <= clr_in; rvalid_ff <= rvalid_in; wvalid_ff <= wvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in; start_ff <= start_in; cur_ff <= cur_in; run_ff <= run_in;
      word_ff <= word_in; addr_ff <= addr_in; fail_ff <= fail_in; fpage_ff <= fpage_in;
   end
endmodule

@@ hw/rtl/bpa_map_ram.sv @@
// Single-port-write, single-port-read bitmap word memory, registered read.
module bpa_map_ram
   import bpa_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [63:0] rd_data
);
   logic [63:0] mem [MapWords];
   logic [63:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr) mem[mem_req.wr_addr] <= mem_req.wr_data;
   end

   // read port
   always_ff @(posedge clock) begin
      if (mem_req.rd) rd_data_ff <= mem[mem_req.rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/bpa_checker.sv @@
// Port-level checker for the page allocator, bound to the top level.
module bpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [27:0] rsp_page_address,
   input logic        rsp_failed
);
   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_page_address) && $stable(rsp_failed))
      else $error("result changed while stalled");
   // failures carry address zero
   a_fail0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_page_address == '0)
      else $error("failed result with nonzero address");
   // no request is taken while a result waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with result pending");
   // an accepted request is followed by a stall in the next cycle
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("two requests in consecutive cycles");
endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the bitmap page allocator: scoreboard, drivers and stimulus.
module tb_top;
   import bpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [27:0] page_address;
      logic        failed;
   } alloc_result_type;

   // Mirror of the page map and hint, plus the queue of results still due
   class alloc_scoreboard;
      bit [63:0]        used_map [MapWords];
      int               hint;
      int               errors;
      int               matched;
      alloc_result_type pending [$];

      // Rebuild the map as a first-free write does
      function void rebuild(int unsigned first_free);
         for (int w = 0; w < MapWords; w++)
            used_map[w] = (w < first_free / WordBits) ? AllOnes : 64'd0;
         hint = first_free;
      endfunction

      // Apply one accepted request to the mirror and queue its result
      function void note_request(logic func, logic [16:0] count, logic [31:0] addr);
         alloc_result_type r;
         int            p;
         int            start;
         int            i;
         int            c;
         longint        byte_addr;
         r.page_address = '0;
         r.failed = 1'b0;
         if (func == FUNC_FREE) begin
            p = int'(addr >> 12);
            if (p < TotalPages) begin
               used_map[p / WordBits][p % WordBits] = 1'b0;
               if (p < hint) hint = p;
            end
         end else if (count == 0) begin
            r.failed = 1'b1;
         end else begin
            start = hint;
            i = 0;
            while (!r.failed && i < int'(count)) begin
               c = start + i;
               if (c >= TotalPages) begin
                  r.failed = 1'b1;
               end else if (used_map[c / WordBits][c % WordBits]) begin
                  start = c + 1;
                  i = 0;
               end else begin
                  i++;
               end
            end
            if (!r.failed) begin
               for (i = 0; i < int'(count); i++)
                  used_map[(start + i) / WordBits][(start + i) % WordBits] = 1'b1;
               hint = start + int'(count);
               byte_addr = longint'(start) * 4096;
               r.page_address = byte_addr[27:0];
            end
         end
         pending.push_back(r);
      endfunction

      // Compare one accepted response with the oldest one due
      function void check_result(logic [27:0] page_address, logic failed);
         alloc_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected response: page_address %h failed %b", page_address, failed);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (page_address !== e.page_address) begin
            $error("page_address: expected %h, got %h", e.page_address, page_address);
            errors++;
         end
         if (failed !== e.failed) begin
            $error("failed: expected %b, got %b", e.failed, failed);
            errors++;
         end
         if (page_address === e.page_address && failed === e.failed) matched++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [16:0] csr_first_free_page;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [16:0] req_page_count;
   logic [31:0] req_free_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [27:0] rsp_page_address;
   logic        rsp_failed;

   alloc_scoreboard sb;
   int send_idle;
   int recv_idle;
   int requests_sent;
   int csr_writes;

   bitmap_page_allocator_unit uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_first_free_page(csr_first_free_page),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_page_count(req_page_count),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_page_address(rsp_page_address),
      .rsp_failed(rsp_failed)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Response side: stall changes on the falling edge
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_idle);
      end
   end

   // Response side: check on the rising edge
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_page_address, rsp_failed);
      end
   end

   // Drive one request, with random idle cycles ahead of it
   task automatic send_request(logic func, logic [16:0] count, logic [31:0] addr);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = func;
      req_page_count = count;
      req_free_address = addr;
      do @(posedge clock); while (req_stall);
      sb.note_request(func, count, addr);
      requests_sent++;
   endtask

   // Write the first-free register once all responses are in
   task automatic write_first_free(logic [16:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_first_free_page = value;
      do @(posedge clock); while (!csr_ready);
      sb.rebuild(value);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random mix of allocations and frees, most frees kept close to the hint
   task automatic run_block(int n, bit near_top);
      int          r;
      int          lo;
      int          hi;
      logic [16:0] count;
      logic [31:0] addr;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 55) begin
            r = $urandom_range(99);
            if (r < 5) count = 17'd0;
            else if (r < 75) count = 17'($urandom_range(8, 1));
            else if (r < 95) count = 17'($urandom_range(64, 9));
            else if (near_top) count = 17'($urandom);
            else count = 17'($urandom_range(300, 65));
            send_request(FUNC_ALLOC, count, 32'($urandom));
         end else begin
            if ($urandom_range(99) < 15) begin
               addr = $urandom | 32'h1000_0000;
            end else begin
               lo = (sb.hint > 300) ? sb.hint - 300 : 0;
               hi = (sb.hint + 20 < TotalPages) ? sb.hint + 20 : TotalPages - 1;
               if (lo > hi) lo = hi;
               addr = (32'($urandom_range(hi, lo)) << 12) | 32'($urandom_range(4095));
            end
            send_request(FUNC_FREE, 17'($urandom), addr);
         end
      end
   endtask

   // Directed cases, then three idling phases of random traffic
   initial begin
      int          cfg;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_first_free_page = '0;
      req_valid = 1'b0;
      req_func = FUNC_ALLOC;
      req_page_count = '0;
      req_free_address = '0;
      rsp_stall = 1'b0;
      send_idle = 0;
      recv_idle = 0;
      requests_sent = 0;
      csr_writes = 0;
      sb = new();
      sb.rebuild(0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty map from page 0: zero count, small runs, frees in and out of range
      send_request(FUNC_ALLOC, 17'd0, 32'd0);
      send_request(FUNC_ALLOC, 17'd1, 32'hFFFF_FFFF);
      send_request(FUNC_ALLOC, 17'd64, 32'd0);
      send_request(FUNC_ALLOC, 17'd3, 32'd0);
      send_request(FUNC_FREE, 17'h1FFFF, 32'h0000_0000);
      send_request(FUNC_FREE, 17'd0, 32'hFFFF_FFFF);
      send_request(FUNC_FREE, 17'd0, 32'h0FFF_FFFF);
      send_request(FUNC_FREE, 17'd0, 32'h003E_8123);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);
      send_request(FUNC_ALLOC, 17'd2, 32'd0);

      // near the top: oversize request, exact fit, then out of memory
      write_first_free(17'd65472);
      send_request(FUNC_ALLOC, 17'h10000, 32'd0);
      send_request(FUNC_ALLOC, 17'd64, 32'd0);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);
      send_request(FUNC_FREE, 17'd0, 32'h0FFF_F000);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);

      // hint at and beyond the top of the map
      write_first_free(17'd65536);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);
      send_request(FUNC_FREE, 17'd0, 32'h0FFF_F000);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);
      write_first_free(17'h1FFFF);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);
      send_request(FUNC_FREE, 17'd0, 32'h0FFF_F000);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);

      // partial word below the boundary stays free
      write_first_free(17'd100);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);
      send_request(FUNC_FREE, 17'd0, 32'h0004_6000);
      send_request(FUNC_ALLOC, 17'd1, 32'd0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 11 : (phase == 1) ? 53 : 0;
         recv_idle = (phase == 0) ? 53 : (phase == 1) ? 11 : 0;
         for (int b = 0; b < 4; b++) begin
            case (b)
               0: cfg = (phase == 0) ? 0 : $urandom_range(2047);
               1: cfg = 65536 - $urandom_range(200);
               2: cfg = $urandom_range(4095);
               default: cfg = (phase == 2) ? 65536 : 64 * $urandom_range(31);
            endcase
            write_first_free(17'(cfg));
            run_block(130, cfg >= 60000);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d requests and %0d first-free writes; %0d responses matched.",
               requests_sent, csr_writes, sb.matched);
      $display("Idling: sender-light, receiver-light and back-to-back phases.");
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_map_ram.sv
hw/rtl/bitmap_page_allocator_unit.sv
hw/rtl/bpa_checker.sv
tb/sv/tb_top.sv
